// ----- rtl/core/sobel_et_pkg.sv -----
// sobel_et_pkg: shared widths, register map, reset values and payload types
// for the streaming sobel edge detector.
// no dependencies; compiled before every other file of the block.
package sobel_et_pkg;

    // pixel and gradient widths
    localparam int PIX_W = 8;

    // configuration register widths
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int THR_W    = 8;

    // apb port geometry
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;

    // register indexes (byte address 4*index)
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST    = 11'd640;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST   = 12'd480;
    localparam logic [THR_W-1:0]    EDGE_THRESHOLD_RST = 8'd40;

    // request kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CNT_W = RQ_AW + 1;

    typedef logic [PIX_W-1:0] pix_t;

    // one result request
    typedef struct packed {
        pix_t edge_x;
        pix_t edge_y;
        pix_t magnitude;
        logic frame_end;
    } result_t;

endpackage

// ----- rtl/core/sobel_et_if.sv -----
// sobel_et_in_if / sobel_et_out_if: valid/ready stream channels of the
// sobel edge detector, input pixels and edge results.
// depends on sobel_et_pkg.
interface sobel_et_in_if;
    import sobel_et_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    pix_t pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface sobel_et_out_if;
    import sobel_et_pkg::*;

    logic valid;
    logic ready;
    pix_t edge_x;
    pix_t edge_y;
    pix_t magnitude;
    logic frame_end;

    modport source (output valid, output edge_x, output edge_y, output magnitude,
                    output frame_end, input ready);
    modport sink   (input valid, input edge_x, input edge_y, input magnitude,
                    input frame_end, output ready);
endinterface

// ----- rtl/core/sobel_edge_threshold_top.sv -----
// Streaming 3x3 sobel edge detector with threshold. The pixel stream takes one
// request per clock while ready is high: the sustained rate is then one pixel or
// flush per cycle, as the line store has one read port and one write port; it is
// read when a request is taken and written when that request leaves the read stage.
// A request passes a line-store read stage and a window stage, whose results
// enter a four-entry result queue. The last pixel of a row and the last flush
// each give two results; the queue hands them out one per cycle while the
// output is ready, and input ready drops only while the queue holds three or more.
// Results lag the input by one row and one column; after the last row, width
// flush requests drain it. Line stores need no clearing pass after reset.
// depends on sobel_et_pkg and the stream interfaces in sobel_et_if.
module sobel_edge_threshold_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sobel_et_pkg::PADDR_W-1:0]    paddr,
    input  logic [sobel_et_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sobel_et_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    sobel_et_in_if.sink                         pixel_stream,
    sobel_et_out_if.source                      edge_stream
);
    import sobel_et_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef struct packed {
        pix_t prev;
        pix_t prev2;
    } line_word_t;

    typedef struct packed {
        logic flush;
        logic first_row;
        logic emit_a;
        logic emit_b;
        logic left_new;
        logic last;
    } stage_ctl_t;

    // sobel kernels on a left/centre/right column triple, abs, saturate, threshold
    function automatic result_t sobel_eval(column_t l, column_t m, column_t r,
                                           pix_t thr, logic last);
        logic [9:0] pos_x;
        logic [9:0] neg_x;
        logic [9:0] pos_y;
        logic [9:0] neg_y;
        logic [9:0] ax;
        logic [9:0] ay;
        pix_t       ex;
        pix_t       ey;
        logic [8:0] sum;
        pix_t       mag;
        result_t    res;
        pos_x = {2'b00, r.top} + {1'b0, r.mid, 1'b0} + {2'b00, r.bot};
        neg_x = {2'b00, l.top} + {1'b0, l.mid, 1'b0} + {2'b00, l.bot};
        pos_y = {2'b00, l.top} + {1'b0, m.top, 1'b0} + {2'b00, r.top};
        neg_y = {2'b00, l.bot} + {1'b0, m.bot, 1'b0} + {2'b00, r.bot};
        ax = (pos_x >= neg_x) ? (pos_x - neg_x) : (neg_x - pos_x);
        ay = (pos_y >= neg_y) ? (pos_y - neg_y) : (neg_y - pos_y);
        ex = (ax > 10'd255) ? 8'hFF : ax[7:0];
        ey = (ay > 10'd255) ? 8'hFF : ay[7:0];
        ex = (ex < thr) ? 8'h00 : ex;
        ey = (ey < thr) ? 8'h00 : ey;
        sum = {1'b0, ex} + {1'b0, ey};
        mag = sum[8] ? 8'hFF : sum[7:0];
        res.edge_x    = ex;
        res.edge_y    = ey;
        res.magnitude = (mag < thr) ? 8'h00 : mag;
        res.frame_end = last;
        return res;
    endfunction

    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [THR_W-1:0]    edge_threshold_reg;

    logic [AW-1:0]       column_count_reg, column_count_next;
    logic [HEIGHT_W-1:0] row_count_reg, row_count_next;
    logic [AW-1:0]       drain_count_reg, drain_count_next;

    logic [AW-1:0]       wm1;
    logic [HEIGHT_W-1:0] h_eff;
    logic                adv;
    logic                in_take;
    logic                is_flush;
    logic                frame_full;
    logic                live;
    logic [AW-1:0]       addr;
    logic                row_end;
    stage_ctl_t          ctl_in;

    line_word_t          line_mem [MAX_WIDTH];
    line_word_t          rd_word_reg;
    logic                mem_we;

    logic                s1_valid_reg;
    stage_ctl_t          s1_ctl_reg;
    pix_t                s1_pixel_reg;
    logic [AW-1:0]       s1_addr_reg;
    column_t             new_col;

    logic                s2_valid_reg;
    stage_ctl_t          s2_ctl_reg;
    column_t             win_reg [3];

    result_t             res_a;
    result_t             res_b;
    logic                push_a;
    logic                push_b;
    logic                pop;
    result_t             rq_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]    rq_wr_ptr_reg;
    logic [RQ_AW-1:0]    rq_rd_ptr_reg;
    logic [RQ_CNT_W-1:0] rq_count_reg;

    // apb register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IMAGE_WIDTH_RST;
            image_height_reg   <= IMAGE_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[PADDR_W-1:2])
                REG_IMAGE_WIDTH:    image_width_reg    <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= pwdata[HEIGHT_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // apb register reads
    always_comb
    begin
        case (paddr[PADDR_W-1:2])
            REG_IMAGE_WIDTH:    prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, image_width_reg};
            REG_IMAGE_HEIGHT:   prdata = {{(APB_DATA_W-HEIGHT_W){1'b0}}, image_height_reg};
            REG_EDGE_THRESHOLD: prdata = {{(APB_DATA_W-THR_W){1'b0}}, edge_threshold_reg};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // effective frame geometry
    always_comb
    begin
        if (image_width_reg < 11'd2)
            wm1 = AW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            wm1 = AW'(MAX_WIDTH - 1);
        else
            wm1 = AW'(image_width_reg - 11'd1);
        h_eff = (image_height_reg < 12'd2) ? 12'd2 : image_height_reg;
    end

    // request decode; pipeline moves while the queue has room for two results
    assign adv                = (rq_count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign pixel_stream.ready = adv;
    assign in_take            = pixel_stream.valid && adv;
    assign is_flush           = (pixel_stream.kind == KIND_FLUSH);
    assign frame_full         = (row_count_reg >= h_eff);
    assign live               = in_take && (is_flush ? frame_full : !frame_full);
    assign addr               = is_flush ? drain_count_reg : column_count_reg;
    assign row_end            = (addr >= wm1);

    always_comb
    begin
        ctl_in.flush     = is_flush;
        ctl_in.first_row = (row_count_reg == 12'd1);
        ctl_in.left_new  = (addr == AW'(1));
        ctl_in.last      = is_flush;
        if (is_flush)
        begin
            ctl_in.emit_a = (addr != '0);
            ctl_in.emit_b = row_end;
        end
        else
        begin
            ctl_in.emit_a = (row_count_reg != '0) && (addr != '0);
            ctl_in.emit_b = (row_count_reg != '0) && row_end;
        end
    end

    // column, row and drain counters
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        drain_count_next  = drain_count_reg;
        if (live)
        begin
            if (!is_flush)
            begin
                if (row_end)
                begin
                    column_count_next = '0;
                    row_count_next    = row_count_reg + 12'd1;
                end
                else
                    column_count_next = addr + AW'(1);
            end
            else
            begin
                if (row_end)
                begin
                    column_count_next = '0;
                    row_count_next    = '0;
                    drain_count_next  = '0;
                end
                else
                    drain_count_next = addr + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            drain_count_reg  <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            drain_count_reg  <= drain_count_next;
        end
    end

    // line store: word holds the previous row and the one before it
    assign mem_we = adv && s1_valid_reg && !s1_ctl_reg.flush;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_addr_reg] <= {s1_pixel_reg, rd_word_reg.prev};
        if (live)
            rd_word_reg <= line_mem[addr];
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= live;
    end

    always_ff @(posedge clk)
    begin
        if (live)
        begin
            s1_ctl_reg   <= ctl_in;
            s1_pixel_reg <= pixel_stream.pixel;
            s1_addr_reg  <= addr;
        end
    end

    // new window column, reflected at the top row and the drained bottom row
    always_comb
    begin
        new_col.mid = rd_word_reg.prev;
        if (s1_ctl_reg.flush)
        begin
            new_col.top = rd_word_reg.prev2;
            new_col.bot = rd_word_reg.prev2;
        end
        else
        begin
            new_col.top = s1_ctl_reg.first_row ? s1_pixel_reg : rd_word_reg.prev2;
            new_col.bot = s1_pixel_reg;
        end
    end

    // window stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
            win_reg[2]   <= '0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                s2_ctl_reg <= s1_ctl_reg;
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= new_col;
            end
        end
    end

    // gradients: centre column result (left border reflected) and the right-border reflected result
    assign res_a = sobel_eval(s2_ctl_reg.left_new ? win_reg[2] : win_reg[0], win_reg[1],
                              win_reg[2], edge_threshold_reg,
                              s2_ctl_reg.last && !s2_ctl_reg.emit_b);
    assign res_b = sobel_eval(win_reg[1], win_reg[2], win_reg[1], edge_threshold_reg,
                              s2_ctl_reg.last);

    assign push_a = adv && s2_valid_reg && s2_ctl_reg.emit_a;
    assign push_b = adv && s2_valid_reg && s2_ctl_reg.emit_b;
    assign pop    = edge_stream.valid && edge_stream.ready;

    // result queue storage, up to two writes a cycle
    always_ff @(posedge clk)
    begin
        if (push_a)
            rq_mem[rq_wr_ptr_reg] <= res_a;
        if (push_a && push_b)
            rq_mem[rq_wr_ptr_reg + RQ_AW'(1)] <= res_b;
        else if (push_b)
            rq_mem[rq_wr_ptr_reg] <= res_b;
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_count_reg  <= '0;
        end
        else
        begin
            rq_wr_ptr_reg <= rq_wr_ptr_reg + RQ_AW'(push_a) + RQ_AW'(push_b);
            rq_rd_ptr_reg <= rq_rd_ptr_reg + RQ_AW'(pop);
            rq_count_reg  <= rq_count_reg + RQ_CNT_W'(push_a) + RQ_CNT_W'(push_b)
                             - RQ_CNT_W'(pop);
        end
    end

    // output channel
    assign edge_stream.valid     = (rq_count_reg != '0);
    assign edge_stream.edge_x    = rq_mem[rq_rd_ptr_reg].edge_x;
    assign edge_stream.edge_y    = rq_mem[rq_rd_ptr_reg].edge_y;
    assign edge_stream.magnitude = rq_mem[rq_rd_ptr_reg].magnitude;
    assign edge_stream.frame_end = rq_mem[rq_rd_ptr_reg].frame_end;

endmodule
